// ===== rtl/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// psq_pkg
// Types, codes and reset values shared by the power rail sequencer files.
// ----------------------------------------------------------------------------
package psq_pkg;

    localparam int TICK_W   = 32;
    localparam int SETTLE_W = 16;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    // rail enable bit positions
    localparam int RAIL_5V   = 0;
    localparam int RAIL_HOST = 1;
    localparam int RAIL_3V3  = 2;
    localparam int RAIL_48V  = 3;
    localparam int RAIL_12V  = 4;
    localparam int RAIL_N    = 5;

    localparam logic [2:0] HOST_STEP_5V       = 3'd0;
    localparam logic [2:0] HOST_STEP_WAIT_OFF = 3'd1;
    localparam logic [2:0] HOST_STEP_SETTLE   = 3'd2;
    localparam logic [2:0] HOST_STEP_POWER    = 3'd3;
    localparam logic [2:0] HOST_STEP_WAIT_RST = 3'd4;
    localparam logic [2:0] HOST_STEP_RST_WAIT = 3'd5;
    localparam logic [2:0] HOST_STEP_3V3      = 3'd6;
    localparam logic [2:0] HOST_STEP_LAST     = 3'd6;

    localparam logic [1:0] MOTOR_STEP_48V    = 2'd0;
    localparam logic [1:0] MOTOR_STEP_SETTLE = 2'd1;
    localparam logic [1:0] MOTOR_STEP_12V    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOST_SETTLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SETTLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTOR_SETTLE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTDOWN_CLEAR  = 2'd3;

    localparam logic [SETTLE_W-1:0] SHUTDOWN_COUNT_MAX = '1;

    typedef struct packed {
        logic off_request_level;
        logic host_reset_level;
        logic switch_event;
        logic off_request_event;
    } psq_item_t;

    typedef struct packed {
        logic rail_5v_on;
        logic host_power_on;
        logic rail_3v3_on;
        logic rail_48v_on;
        logic rail_12v_on;
        logic switch_clear_level;
        logic buzzer_start;
        logic host_ready;
        logic motor_ready;
        logic system_enabled;
    } psq_result_t;

    typedef struct packed {
        logic [SETTLE_W-1:0] host_settle_ticks;
        logic [SETTLE_W-1:0] reset_settle_ticks;
        logic [SETTLE_W-1:0] motor_settle_ticks;
        logic [SETTLE_W-1:0] shutdown_clear_ticks;
    } psq_cfg_t;

    typedef struct packed {
        logic                mode_flag;
        logic [2:0]          host_step;
        logic [TICK_W-1:0]   host_mark;
        logic [1:0]          motor_step;
        logic [TICK_W-1:0]   motor_mark;
        logic [TICK_W-1:0]   tick_count;
        logic                host_done;
        logic                motor_done;
        logic [RAIL_N-1:0]   rail_enables;
        logic                shutdown_latched;
        logic [SETTLE_W-1:0] shutdown_count;
        logic                switch_clear;
    } psq_state_t;

    localparam psq_cfg_t PSQ_CFG_RESET = '{
        host_settle_ticks:    16'd50,
        reset_settle_ticks:   16'd20,
        motor_settle_ticks:   16'd50,
        shutdown_clear_ticks: 16'd300
    };

    localparam psq_state_t PSQ_STATE_RESET = '{
        mode_flag:        1'b0,
        host_step:        HOST_STEP_5V,
        host_mark:        '0,
        motor_step:       MOTOR_STEP_48V,
        motor_mark:       '0,
        tick_count:       '0,
        host_done:        1'b0,
        motor_done:       1'b0,
        rail_enables:     '0,
        shutdown_latched: 1'b0,
        shutdown_count:   '0,
        switch_clear:     1'b1
    };

endpackage

// ===== rtl/power_rail_sequencer.sv =====
// ----------------------------------------------------------------------------
// power_rail_sequencer
// Host and motor supply power-up sequencer with shutdown count, one tick a beat.
// ----------------------------------------------------------------------------
// Each input beat is one control tick. A beat is taken into an input register,
// run through the single-pass step logic and placed in the result register, and
// the block sustains one beat per clock while results are taken; while a result
// waits for m_tready the input register takes one more beat and then stalls, so
// s_tready drops only when both registers are full.
// Settle times and the shutdown clear count must be written through the cfg port
// only while no beat is in flight; the block itself does not enforce this.
module power_rail_sequencer
    import psq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SETTLE_W-1:0]   cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata: off_request_level, host_reset_level, switch_event,
    // off_request_event, then zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: rail_5v_on, host_power_on, rail_3v3_on, rail_48v_on,
    // rail_12v_on, switch_clear_level, buzzer_start, host_ready,
    // motor_ready, system_enabled, then zero fill
    output logic [M_TDATA_W-1:0]  m_tdata
);

    psq_cfg_t    cfg_reg;
    psq_state_t  state_reg;
    psq_state_t  state_next;
    psq_item_t   item_reg;
    psq_result_t result_next;
    psq_result_t result_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        fire;
    logic        take;

    psq_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .item      (item_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PSQ_STATE_RESET;
            cfg_reg       <= PSQ_CFG_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (fire)
                state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HOST_SETTLE:    cfg_reg.host_settle_ticks    <= cfg_wdata;
                    CFG_RESET_SETTLE:   cfg_reg.reset_settle_ticks   <= cfg_wdata;
                    CFG_MOTOR_SETTLE:   cfg_reg.motor_settle_ticks   <= cfg_wdata;
                    CFG_SHUTDOWN_CLEAR: cfg_reg.shutdown_clear_ticks <= cfg_wdata;
                endcase
            end
        end
    end

    // payload registers, qualified by the valid flags
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.off_request_level <= s_tdata[0];
            item_reg.host_reset_level  <= s_tdata[1];
            item_reg.switch_event      <= s_tdata[2];
            item_reg.off_request_event <= s_tdata[3];
        end
        if (fire)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {
        {(M_TDATA_W-10){1'b0}},
        result_reg.system_enabled,
        result_reg.motor_ready,
        result_reg.host_ready,
        result_reg.buzzer_start,
        result_reg.switch_clear_level,
        result_reg.rail_12v_on,
        result_reg.rail_48v_on,
        result_reg.rail_3v3_on,
        result_reg.host_power_on,
        result_reg.rail_5v_on
    };

endmodule

// ===== rtl/psq_step.sv =====
// ----------------------------------------------------------------------------
// psq_step
// Next-state and result logic for one tick of the rail sequencer.
// ----------------------------------------------------------------------------
module psq_step
    import psq_pkg::*;
(
    input  psq_state_t  state_cur,
    input  psq_cfg_t    cfg,
    input  psq_item_t   item,
    output psq_state_t  state_nxt,
    output psq_result_t result
);

    function automatic logic still_waiting(
        input logic [TICK_W-1:0]   tick,
        input logic [TICK_W-1:0]   mark,
        input logic [SETTLE_W-1:0] settle
    );
        logic [TICK_W-1:0] elapsed;
        begin
            elapsed = tick - mark;
            still_waiting = elapsed < {{(TICK_W-SETTLE_W){1'b0}}, settle};
        end
    endfunction

    // host steps fall through in one tick until a wait is not yet met
    function automatic psq_state_t host_seq(
        input psq_state_t s_in,
        input psq_cfg_t   c,
        input logic       offreq,
        input logic       rst
    );
        psq_state_t s;
        logic       stop;
        begin
            s    = s_in;
            stop = 1'b0;
            if (s.host_step > HOST_STEP_LAST)
            begin
                s.host_step = HOST_STEP_5V;
                stop = 1'b1;
            end
            if (!stop && s.host_step == HOST_STEP_5V)
            begin
                s.rail_enables[RAIL_5V] = 1'b1;
                s.host_step = HOST_STEP_WAIT_OFF;
            end
            if (!stop && s.host_step == HOST_STEP_WAIT_OFF)
            begin
                if (!offreq)
                    stop = 1'b1;
                else
                begin
                    s.host_mark = s.tick_count;
                    s.host_step = HOST_STEP_SETTLE;
                end
            end
            if (!stop && s.host_step == HOST_STEP_SETTLE)
            begin
                if (still_waiting(s.tick_count, s.host_mark, c.host_settle_ticks))
                    stop = 1'b1;
                else
                    s.host_step = HOST_STEP_POWER;
            end
            if (!stop && s.host_step == HOST_STEP_POWER)
            begin
                s.rail_enables[RAIL_HOST] = 1'b1;
                s.host_step = HOST_STEP_WAIT_RST;
            end
            if (!stop && s.host_step == HOST_STEP_WAIT_RST)
            begin
                if (!rst)
                    stop = 1'b1;
                else
                begin
                    s.host_mark = s.tick_count;
                    s.host_step = HOST_STEP_RST_WAIT;
                end
            end
            if (!stop && s.host_step == HOST_STEP_RST_WAIT)
            begin
                if (still_waiting(s.tick_count, s.host_mark, c.reset_settle_ticks))
                    stop = 1'b1;
                else
                    s.host_step = HOST_STEP_3V3;
            end
            if (!stop && s.host_step == HOST_STEP_3V3)
            begin
                s.rail_enables[RAIL_3V3] = 1'b1;
                s.host_done = 1'b1;
                s.host_step = HOST_STEP_5V;
            end
            host_seq = s;
        end
    endfunction

    function automatic psq_state_t motor_seq(
        input psq_state_t s_in,
        input psq_cfg_t   c
    );
        psq_state_t s;
        logic       go_on;
        begin
            s = s_in;
            go_on = 1'b0;
            unique case (s.motor_step)
                MOTOR_STEP_48V:
                begin
                    s.rail_enables[RAIL_48V] = 1'b1;
                    s.motor_mark = s.tick_count;
                    s.motor_step = MOTOR_STEP_SETTLE;
                end
                MOTOR_STEP_SETTLE:
                begin
                    go_on = !still_waiting(s.tick_count, s.motor_mark,
                                           c.motor_settle_ticks);
                end
                MOTOR_STEP_12V:
                begin
                    go_on = 1'b1;
                end
                default:
                begin
                    s.motor_step = MOTOR_STEP_48V;
                end
            endcase
            if (go_on)
            begin
                s.rail_enables[RAIL_12V] = 1'b1;
                s.motor_done = 1'b1;
                s.motor_step = MOTOR_STEP_48V;
            end
            motor_seq = s;
        end
    endfunction

    psq_state_t st;
    logic       buzz;
    logic       enter;

    always_comb
    begin
        st    = state_cur;
        buzz  = 1'b0;
        enter = 1'b0;

        if (item.switch_event)
            st.shutdown_latched = 1'b1;
        if (item.off_request_event)
        begin
            st.rail_enables = '0;
            st.host_done    = 1'b0;
        end

        if (st.shutdown_latched)
        begin
            if (st.shutdown_count == '0)
                buzz = 1'b1;
            else if (st.shutdown_count == cfg.shutdown_clear_ticks)
                st.switch_clear = 1'b0;
            if (st.shutdown_count != SHUTDOWN_COUNT_MAX)
                st.shutdown_count = st.shutdown_count + 1'b1;
        end

        if (!st.mode_flag)
        begin
            if (!st.host_done)
                st = host_seq(st, cfg, item.off_request_level, item.host_reset_level);
            else if (!st.motor_done)
                st = motor_seq(st, cfg);
            else
                enter = 1'b1;
            st.tick_count = st.tick_count + 1'b1;
            if (enter)
            begin
                st.mode_flag  = 1'b1;
                st.tick_count = '0;
            end
        end
        else
        begin
            if (!st.host_done && item.off_request_level)
                st = host_seq(st, cfg, item.off_request_level, item.host_reset_level);
            if (!st.motor_done)
                st = motor_seq(st, cfg);
            st.tick_count = st.tick_count + 1'b1;
        end
    end

    assign state_nxt = st;

    assign result.rail_5v_on         = st.rail_enables[RAIL_5V];
    assign result.host_power_on      = st.rail_enables[RAIL_HOST];
    assign result.rail_3v3_on        = st.rail_enables[RAIL_3V3];
    assign result.rail_48v_on        = st.rail_enables[RAIL_48V];
    assign result.rail_12v_on        = st.rail_enables[RAIL_12V];
    assign result.switch_clear_level = st.switch_clear;
    assign result.buzzer_start       = buzz;
    assign result.host_ready         = st.host_done;
    assign result.motor_ready        = st.motor_done;
    assign result.system_enabled     = st.mode_flag;

endmodule

// ===== rtl/psq_checker.sv =====
// ----------------------------------------------------------------------------
// psq_checker
// Port-level checks for the power rail sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module psq_checker
    import psq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // with the result side empty the input side always takes a beat
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result waiting");

    // 12v is only turned on together with motor ready, which never clears
    a_12v_motor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[8])
        else $error("12v on without motor ready");

    // host ready is set with 3v3 and both drop on an off-request edge
    a_host_3v3: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[7] |-> m_tdata[2])
        else $error("host ready without 3v3");

    // enable state is entered only after the motor sequence is done
    a_enable_motor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[9] |-> m_tdata[8])
        else $error("enable state without motor ready");

endmodule

bind power_rail_sequencer psq_checker u_psq_checker (.*);

// ===== tb/tb_power_rail_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_rail_sequencer
// Self-checking bench for the host and motor power rail sequencer.
// ----------------------------------------------------------------------------
// Ticks are streamed in with bursty valid while the result side stalls on its
// own pattern. Every accepted tick is run through a local model of the rail
// sequencer and the predicted rail status is queued; each result beat is
// compared field by field against the oldest entry. The run covers the
// register reset values, zero and maximum settle times, off-request edges in
// both modes, the shutdown count with buzzer pulse and clear line, a long
// result-side hold-off and random pin activity.
// ----------------------------------------------------------------------------
module tb_power_rail_sequencer;
    import psq_pkg::*;

    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int STATUS_N        = 10;

    localparam logic [SETTLE_W-1:0] DEF_HOST_SETTLE   = 16'd50;
    localparam logic [SETTLE_W-1:0] DEF_RESET_SETTLE  = 16'd20;
    localparam logic [SETTLE_W-1:0] DEF_MOTOR_SETTLE  = 16'd50;
    localparam logic [SETTLE_W-1:0] DEF_CLEAR_TICKS   = 16'd300;
    localparam logic [SETTLE_W-1:0] SETTLE_MAX        = 16'hFFFF;

    // result-side stall patterns
    localparam int RX_STEADY   = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_PERIODIC = 2;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [SETTLE_W-1:0]   cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    // s_tdata: off_request_level, host_reset_level, switch_event,
    // off_request_event, then zero fill
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // m_tdata: rail_5v_on, host_power_on, rail_3v3_on, rail_48v_on,
    // rail_12v_on, switch_clear_level, buzzer_start, host_ready,
    // motor_ready, system_enabled, then zero fill
    logic [M_TDATA_W-1:0]  m_tdata;

    power_rail_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    psq_state_t   seq;
    psq_cfg_t     thresholds;
    psq_result_t  rail_status_q [$];
    psq_result_t  want;
    logic [STATUS_N-1:0] want_bits;

    int  errors      = 0;
    int  burst_left  = 0;
    int  idle_cycles = 0;
    int  rx_mode     = RX_STEADY;
    int  rx_left     = 0;
    int  rx_cycle    = 0;
    int  hold_left   = 0;
    bit  hold_off_req = 1'b0;
    bit  lvl_off     = 1'b0;
    bit  lvl_rst     = 1'b0;

    string status_name [STATUS_N] = '{
        "rail_5v_on", "host_power_on", "rail_3v3_on", "rail_48v_on",
        "rail_12v_on", "switch_clear_level", "buzzer_start", "host_ready",
        "motor_ready", "system_enabled"
    };

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------
    task automatic run_host_steps(input logic offreq, input logic rst);
        logic [TICK_W-1:0] elapsed;
        if (seq.host_step > HOST_STEP_LAST)
        begin
            seq.host_step = HOST_STEP_5V;
            return;
        end
        if (seq.host_step == HOST_STEP_5V)
        begin
            seq.rail_enables[RAIL_5V] = 1'b1;
            seq.host_step = HOST_STEP_WAIT_OFF;
        end
        if (seq.host_step == HOST_STEP_WAIT_OFF)
        begin
            if (!offreq)
                return;
            seq.host_mark = seq.tick_count;
            seq.host_step = HOST_STEP_SETTLE;
        end
        if (seq.host_step == HOST_STEP_SETTLE)
        begin
            elapsed = seq.tick_count - seq.host_mark;
            if (elapsed < {16'd0, thresholds.host_settle_ticks})
                return;
            seq.host_step = HOST_STEP_POWER;
        end
        if (seq.host_step == HOST_STEP_POWER)
        begin
            seq.rail_enables[RAIL_HOST] = 1'b1;
            seq.host_step = HOST_STEP_WAIT_RST;
        end
        if (seq.host_step == HOST_STEP_WAIT_RST)
        begin
            if (!rst)
                return;
            seq.host_mark = seq.tick_count;
            seq.host_step = HOST_STEP_RST_WAIT;
        end
        if (seq.host_step == HOST_STEP_RST_WAIT)
        begin
            elapsed = seq.tick_count - seq.host_mark;
            if (elapsed < {16'd0, thresholds.reset_settle_ticks})
                return;
            seq.host_step = HOST_STEP_3V3;
        end
        if (seq.host_step == HOST_STEP_3V3)
        begin
            seq.rail_enables[RAIL_3V3] = 1'b1;
            seq.host_done = 1'b1;
            seq.host_step = HOST_STEP_5V;
        end
    endtask

    task automatic run_motor_steps();
        logic [TICK_W-1:0] elapsed;
        if (seq.motor_step == MOTOR_STEP_48V)
        begin
            seq.rail_enables[RAIL_48V] = 1'b1;
            seq.motor_mark = seq.tick_count;
            seq.motor_step = MOTOR_STEP_SETTLE;
            return;
        end
        if (seq.motor_step == MOTOR_STEP_SETTLE)
        begin
            elapsed = seq.tick_count - seq.motor_mark;
            if (elapsed < {16'd0, thresholds.motor_settle_ticks})
                return;
            seq.motor_step = MOTOR_STEP_12V;
        end
        if (seq.motor_step == MOTOR_STEP_12V)
        begin
            seq.rail_enables[RAIL_12V] = 1'b1;
            seq.motor_done = 1'b1;
            seq.motor_step = MOTOR_STEP_48V;
            return;
        end
        seq.motor_step = MOTOR_STEP_48V;
    endtask

    task automatic step_sequencer(input psq_item_t it, output psq_result_t r);
        logic buzz;
        logic enter;
        buzz  = 1'b0;
        enter = 1'b0;
        if (it.switch_event)
            seq.shutdown_latched = 1'b1;
        if (it.off_request_event)
        begin
            seq.rail_enables = '0;
            seq.host_done = 1'b0;
        end
        if (seq.shutdown_latched)
        begin
            // count zero gives the buzzer pulse and never the clear
            if (seq.shutdown_count == '0)
                buzz = 1'b1;
            else if (seq.shutdown_count == thresholds.shutdown_clear_ticks)
                seq.switch_clear = 1'b0;
            if (seq.shutdown_count != SHUTDOWN_COUNT_MAX)
                seq.shutdown_count = seq.shutdown_count + 1'b1;
        end
        if (!seq.mode_flag)
        begin
            if (!seq.host_done)
                run_host_steps(it.off_request_level, it.host_reset_level);
            else if (!seq.motor_done)
                run_motor_steps();
            else
                enter = 1'b1;
            seq.tick_count = seq.tick_count + 1'b1;
            if (enter)
            begin
                seq.mode_flag  = 1'b1;
                seq.tick_count = '0;
            end
        end
        else
        begin
            if (!seq.host_done && it.off_request_level)
                run_host_steps(it.off_request_level, it.host_reset_level);
            if (!seq.motor_done)
                run_motor_steps();
            seq.tick_count = seq.tick_count + 1'b1;
        end
        r.rail_5v_on         = seq.rail_enables[RAIL_5V];
        r.host_power_on      = seq.rail_enables[RAIL_HOST];
        r.rail_3v3_on        = seq.rail_enables[RAIL_3V3];
        r.rail_48v_on        = seq.rail_enables[RAIL_48V];
        r.rail_12v_on        = seq.rail_enables[RAIL_12V];
        r.switch_clear_level = seq.switch_clear;
        r.buzzer_start       = buzz;
        r.host_ready         = seq.host_done;
        r.motor_ready        = seq.motor_done;
        r.system_enabled     = seq.mode_flag;
    endtask

    // ------------------------------------------------------------------
    // stimulus side
    // ------------------------------------------------------------------
    task automatic send_tick(input psq_item_t it);
        int gap;
        psq_result_t r;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, it.off_request_event, it.switch_event,
                     it.host_reset_level, it.off_request_level};
        do @(posedge clk); while (!s_tready);
        step_sequencer(it, r);
        rail_status_q.push_back(r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (rail_status_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [SETTLE_W-1:0] host_ticks,
                                  input logic [SETTLE_W-1:0] reset_ticks,
                                  input logic [SETTLE_W-1:0] motor_ticks,
                                  input logic [SETTLE_W-1:0] clear_ticks);
        logic [CFG_IDX_W-1:0] idx  [4];
        logic [SETTLE_W-1:0]  vals [4];
        idx  = '{CFG_HOST_SETTLE, CFG_RESET_SETTLE, CFG_MOTOR_SETTLE, CFG_SHUTDOWN_CLEAR};
        vals = '{host_ticks, reset_ticks, motor_ticks, clear_ticks};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        thresholds = '{host_ticks, reset_ticks, motor_ticks, clear_ticks};
    endtask

    task automatic random_thresholds(input int unsigned max_ticks);
        set_thresholds(SETTLE_W'($urandom_range(0, max_ticks)),
                       SETTLE_W'($urandom_range(0, max_ticks)),
                       SETTLE_W'($urandom_range(0, max_ticks)),
                       SETTLE_W'($urandom_range(0, max_ticks)));
    endtask

    // pin levels are held in runs so the host sequence gets past its waits
    function automatic psq_item_t random_tick(input int pct_offev, input int pct_sw,
                                              input int pct_noise);
        psq_item_t  it;
        logic [3:0] raw;
        if ($urandom_range(0, 99) < pct_noise)
        begin
            raw = 4'($urandom_range(0, 15));
            it  = psq_item_t'(raw);
            return it;
        end
        if (lvl_off)
            lvl_off = ($urandom_range(0, 99) >= 3);
        else
            lvl_off = ($urandom_range(0, 99) < 20);
        if (lvl_rst)
            lvl_rst = ($urandom_range(0, 99) >= 4);
        else
            lvl_rst = ($urandom_range(0, 99) < 15);
        it.off_request_level = lvl_off;
        it.host_reset_level  = lvl_rst;
        it.switch_event      = ($urandom_range(0, 99) < pct_sw);
        it.off_request_event = ($urandom_range(0, 99) < pct_offev);
        return it;
    endfunction

    task automatic run_random(input int n, input int pct_offev, input int pct_sw,
                              input int pct_noise);
        repeat (n)
            send_tick(random_tick(pct_offev, pct_sw, pct_noise));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_values();
        // default host settle holds the sequence with only 5V up
        repeat (5)
            send_tick(psq_item_t'(4'b1100));
        drain_results();
    endtask

    task automatic test_directed();
        // codes are {off_request_level, host_reset_level, switch_event,
        // off_request_event}
        logic [3:0] directed_ticks [15];
        directed_ticks = '{
            4'b0000,  // settle passes, host power up, waiting on reset
            4'b0100,  // reset high, 3V3 comes up with host ready
            4'b0001,  // off edge drops the rails, 5V back up, waiting on off-request
            4'b1000,  // zero settle, host power in the same tick
            4'b1010,  // switch event, buzzer pulse at count zero
            4'b1010,  // second switch while latched
            4'b1101,  // off edge then reset high, only 3V3 comes up
            4'b1100,  // 48V
            4'b1100,  // zero motor settle, 12V
            4'b1100,  // enter enable
            4'b0001,  // off edge in enable with pin low, no rerun
            4'b0000,
            4'b1000,  // host rerun up to the reset wait
            4'b1111,  // every input high
            4'b0000
        };
        // zero clear count must not drive the line low at count zero
        set_thresholds('0, '0, '0, '0);
        foreach (directed_ticks[i])
            send_tick(psq_item_t'(directed_ticks[i]));
        drain_results();
        set_thresholds('0, '0, '0, seq.shutdown_count + 16'd2);
        repeat (3)
            send_tick(psq_item_t'(4'b0000));
        drain_results();
    endtask

    task automatic test_host_reruns();
        repeat (5)
        begin
            random_thresholds(12);
            run_random(80, 5, 1, 5);
            drain_results();
        end
    endtask

    task automatic test_default_settles();
        set_thresholds(DEF_HOST_SETTLE, DEF_RESET_SETTLE, DEF_MOTOR_SETTLE,
                       DEF_CLEAR_TICKS);
        run_random(350, 2, 1, 5);
        drain_results();
    endtask

    task automatic test_extreme_settles();
        set_thresholds(SETTLE_MAX, SETTLE_MAX, SETTLE_MAX, SETTLE_MAX);
        run_random(100, 5, 1, 5);
        drain_results();
        set_thresholds('0, SETTLE_MAX, '0, '0);
        run_random(100, 5, 1, 5);
        drain_results();
    endtask

    task automatic test_input_backpressure();
        random_thresholds(8);
        hold_off_req = 1'b1;
        run_random(200, 4, 1, 5);
        drain_results();
    endtask

    task automatic test_noise();
        repeat (2)
        begin
            random_thresholds(SETTLE_MAX);
            run_random(60, 10, 10, 100);
            drain_results();
            random_thresholds(4);
            run_random(60, 10, 10, 100);
            drain_results();
        end
    endtask

    // ------------------------------------------------------------------
    // result side: stall pattern and checking
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rail_status_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = rail_status_q.pop_front();
                want_bits = {want.system_enabled, want.motor_ready, want.host_ready,
                             want.buzzer_start, want.switch_clear_level, want.rail_12v_on,
                             want.rail_48v_on, want.rail_3v3_on, want.host_power_on,
                             want.rail_5v_on};
                for (int i = 0; i < STATUS_N; i++)
                begin
                    if (m_tdata[i] !== want_bits[i])
                    begin
                        $display("%0t: %s expected %0b actual %0b", $time, status_name[i],
                                 want_bits[i], m_tdata[i]);
                        errors++;
                    end
                end
            end
        end
        if (hold_off_req)
        begin
            hold_left    = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(RX_STEADY, RX_PERIODIC);
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_RANDOM: m_tready <= ($urandom_range(0, 9) >= 3);
                default:   m_tready <= ((rx_cycle % 4) == 0);
            endcase
        end
    end

    // stop if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        seq = '0;
        seq.switch_clear = 1'b1;
        thresholds = '{DEF_HOST_SETTLE, DEF_RESET_SETTLE, DEF_MOTOR_SETTLE, DEF_CLEAR_TICKS};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_directed();
        test_host_reruns();
        test_default_settles();
        test_extreme_settles();
        test_input_backpressure();
        test_noise();
        drain_results();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/psq_pkg.sv
rtl/psq_step.sv
rtl/power_rail_sequencer.sv
rtl/psq_checker.sv
tb/tb_power_rail_sequencer.sv
